// ===== rtl/slht_pkg.sv =====
// Package for the subscription lease and heartbeat table.
// Shared codes, widths, reset values, controller types and time helpers.
// No dependencies.
package slht_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int ID_BITS_DEF     = 32;

   localparam int TIME_W    = 32;
   localparam int CFG_W     = 20;
   localparam int PAD_W     = TIME_W - CFG_W;
   localparam int CFG_IDX_W = 2;
   localparam int ACT_W     = 2;
   localparam int KIND_W    = 4;
   localparam int FWD_W     = 2;
   localparam int CLIENT_W  = 32;

   localparam logic [CFG_W-1:0] LEASE_RST     = 20'd10000;
   localparam logic [CFG_W-1:0] HEARTBEAT_RST = 20'd5000;
   localparam logic [CFG_W-1:0] CHECK_RST     = 20'd1000;

   typedef enum logic [ACT_W-1:0] {
      ACT_UPDATE  = 2'd0,
      ACT_DELETE  = 2'd1,
      ACT_DELIVER = 2'd2,
      ACT_TICK    = 2'd3
   } act_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_NEW       = 4'd0,
      KIND_REFRESHED = 4'd1,
      KIND_DELETED   = 4'd2,
      KIND_ROUTED    = 4'd3,
      KIND_DROPPED   = 4'd4,
      KIND_EXPIRED   = 4'd5,
      KIND_HEARTBEAT = 4'd6,
      KIND_DONE      = 4'd7,
      KIND_FULL      = 4'd8
   } kind_type;

   typedef enum logic [FWD_W-1:0] {
      FWD_NONE   = 2'd0,
      FWD_UPDATE = 2'd1,
      FWD_DELETE = 2'd2
   } fwd_type;

   typedef enum logic [CFG_IDX_W-1:0] {
      CSR_LEASE     = 2'd0,
      CSR_HEARTBEAT = 2'd1,
      CSR_CHECK     = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SW_RD,
      ST_SW_EVAL,
      ST_SW_DONE
   } state_type;

   typedef struct packed {
      logic latch;
      logic exec;
      logic sw_eval;
      logic sw_done;
   } cmd_type;

   typedef struct packed {
      logic tick_due;
      logic sw_last;
   } stat_type;

   // true when now has reached t, by wrapped signed difference
   function automatic logic reached(input logic [TIME_W-1:0] now,
                                    input logic [TIME_W-1:0] t);
      logic [TIME_W-1:0] diff;
      diff = now - t;
      return !diff[TIME_W-1];
   endfunction

endpackage

// ===== rtl/slht_ram.sv =====
// Generic single write port RAM with registered read.
// Used for the per-entry deadline stores. No dependencies.
module slht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/slht_ctrl.sv =====
// Controller for the subscription lease and heartbeat table.
// Sequences accept, execute and the table sweep. Depends on slht_pkg.
module slht_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  slht_pkg::stat_type stat,
   output slht_pkg::cmd_type  cmd
);

   slht_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slht_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         slht_pkg::ST_IDLE: begin
            if (start) begin
               state_in = slht_pkg::ST_EXEC;
            end
         end
         slht_pkg::ST_EXEC: begin
            if (stat.tick_due) begin
               state_in = slht_pkg::ST_SW_RD;
            end else begin
               state_in = slht_pkg::ST_IDLE;
            end
         end
         slht_pkg::ST_SW_RD: begin
            state_in = slht_pkg::ST_SW_EVAL;
         end
         slht_pkg::ST_SW_EVAL: begin
            if (stat.sw_last) begin
               state_in = slht_pkg::ST_SW_DONE;
            end else begin
               state_in = slht_pkg::ST_SW_RD;
            end
         end
         slht_pkg::ST_SW_DONE: begin
            state_in = slht_pkg::ST_IDLE;
         end
         default: begin
            state_in = slht_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         slht_pkg::ST_IDLE: begin
            busy      = 1'b0;
            cmd.latch = start;
         end
         slht_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         slht_pkg::ST_SW_RD: begin
         end
         slht_pkg::ST_SW_EVAL: begin
            cmd.sw_eval = 1'b1;
         end
         slht_pkg::ST_SW_DONE: begin
            cmd.sw_done = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/slht_dp.sv =====
// Datapath for the subscription lease and heartbeat table: config registers,
// client match array, deadline RAMs and result register. Depends on slht_pkg
// and slht_ram.
module slht_dp #(
   parameter int TABLE_DEPTH = slht_pkg::TABLE_DEPTH_DEF,
   parameter int ID_BITS     = slht_pkg::ID_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  slht_pkg::cmd_type                    cmd,
   output slht_pkg::stat_type                   stat,
   input  logic [slht_pkg::ACT_W-1:0]           req_action,
   input  logic [slht_pkg::CLIENT_W-1:0]        req_client_id,
   input  logic [slht_pkg::TIME_W-1:0]          req_now_ms,
   input  logic                                 csr_we,
   input  logic [slht_pkg::CFG_IDX_W-1:0]       csr_index,
   input  logic [slht_pkg::CFG_W-1:0]           csr_wdata,
   output logic                                 rsp_valid,
   output logic [slht_pkg::KIND_W-1:0]          rsp_kind,
   output logic [slht_pkg::CLIENT_W-1:0]        rsp_client_id_out,
   output logic [slht_pkg::FWD_W-1:0]           rsp_forward_command,
   output logic                                 rsp_last
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int TW    = slht_pkg::TIME_W;
   localparam int CW    = slht_pkg::CLIENT_W;

   // latched input word
   slht_pkg::act_type act_ff;
   logic [ID_BITS-1:0] id_ff;
   logic [TW-1:0]      now_ff;
   logic [ID_BITS+CW-1:0] id_ext;

   // configuration
   logic [slht_pkg::CFG_W-1:0] lease_ff, hb_ff, chk_ff;
   logic [TW-1:0]              hb_off;

   // table state
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [TABLE_DEPTH-1:0] dead_ff, dead_in;
   logic [ID_BITS-1:0]     client_ff [TABLE_DEPTH];
   logic                   client_we;
   logic [TW-1:0]          next_check_ff, next_check_in;
   logic [IDX_W-1:0]       sw_idx_ff, sw_idx_in;

   // lookup
   logic [TABLE_DEPTH-1:0] hit_vec;
   logic                   hit_any, free_any;
   logic [IDX_W-1:0]       hit_idx, free_idx;

   // deadline RAM ports
   logic             exp_we, hbt_we;
   logic [IDX_W-1:0] exp_waddr, hbt_waddr;
   logic [TW-1:0]    exp_wdata, hbt_wdata;
   logic [TW-1:0]    exp_rd, hbt_rd;

   logic [TW-1:0] new_exp, new_hb, new_check;

   // result
   logic                   out_fire, out_last;
   slht_pkg::kind_type     out_kind;
   slht_pkg::fwd_type      out_fwd;
   logic [ID_BITS-1:0]     out_client;
   logic [ID_BITS+CW-1:0]  out_ext;

   logic                   rsp_valid_ff;
   slht_pkg::kind_type     rsp_kind_ff;
   logic [CW-1:0]          rsp_client_ff;
   slht_pkg::fwd_type      rsp_fwd_ff;
   logic                   rsp_last_ff;

   logic               cur_valid, cur_dead;
   logic [ID_BITS-1:0] cur_client;

   assign id_ext = {{ID_BITS{1'b0}}, req_client_id};

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         act_ff <= slht_pkg::act_type'(req_action);
         id_ff  <= id_ext[ID_BITS-1:0];
         now_ff <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lease_ff <= slht_pkg::LEASE_RST;
         hb_ff    <= slht_pkg::HEARTBEAT_RST;
         chk_ff   <= slht_pkg::CHECK_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            slht_pkg::CSR_LEASE:     lease_ff <= csr_wdata;
            slht_pkg::CSR_HEARTBEAT: hb_ff    <= csr_wdata;
            slht_pkg::CSR_CHECK:     chk_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // heartbeat offset = period - check interval, mod 2^32
   assign hb_off = {{slht_pkg::PAD_W{1'b0}}, hb_ff} - {{slht_pkg::PAD_W{1'b0}}, chk_ff};

   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit_vec[i] = valid_ff[i] && (client_ff[i] == id_ff);
      end
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
      hit_any  = |hit_vec;
      free_any = ~&valid_ff;
   end

   assign new_exp   = now_ff + {{slht_pkg::PAD_W{1'b0}}, lease_ff};
   assign new_hb    = now_ff + hb_off;
   assign new_check = now_ff + {{slht_pkg::PAD_W{1'b0}}, chk_ff};

   assign cur_valid  = valid_ff[sw_idx_ff];
   assign cur_dead   = dead_ff[sw_idx_ff];
   assign cur_client = client_ff[sw_idx_ff];

   assign stat.tick_due = (act_ff == slht_pkg::ACT_TICK) &&
                          slht_pkg::reached(now_ff, next_check_ff);
   assign stat.sw_last  = (sw_idx_ff == IDX_W'(TABLE_DEPTH - 1));

   always_comb begin
      valid_in      = valid_ff;
      dead_in       = dead_ff;
      client_we     = 1'b0;
      next_check_in = next_check_ff;
      sw_idx_in     = sw_idx_ff;
      exp_we        = 1'b0;
      exp_waddr     = hit_idx;
      exp_wdata     = new_exp;
      hbt_we        = 1'b0;
      hbt_waddr     = hit_idx;
      hbt_wdata     = new_hb;
      out_fire      = 1'b0;
      out_kind      = slht_pkg::KIND_DONE;
      out_client    = id_ff;
      out_fwd       = slht_pkg::FWD_NONE;
      out_last      = 1'b1;

      if (cmd.exec) begin
         unique case (act_ff)
            slht_pkg::ACT_UPDATE: begin
               out_fire = 1'b1;
               if (hit_any) begin
                  exp_we           = 1'b1;
                  dead_in[hit_idx] = 1'b0;
                  out_kind         = slht_pkg::KIND_REFRESHED;
                  out_fwd          = slht_pkg::FWD_UPDATE;
               end else if (free_any) begin
                  valid_in[free_idx] = 1'b1;
                  dead_in[free_idx]  = 1'b0;
                  client_we          = 1'b1;
                  exp_we             = 1'b1;
                  exp_waddr          = free_idx;
                  hbt_we             = 1'b1;
                  hbt_waddr          = free_idx;
                  out_kind           = slht_pkg::KIND_NEW;
                  out_fwd            = slht_pkg::FWD_UPDATE;
               end else begin
                  out_kind = slht_pkg::KIND_FULL;
               end
            end
            slht_pkg::ACT_DELETE: begin
               out_fire = 1'b1;
               if (hit_any) begin
                  valid_in[hit_idx] = 1'b0;
                  dead_in[hit_idx]  = 1'b0;
               end
               out_kind = slht_pkg::KIND_DELETED;
               out_fwd  = slht_pkg::FWD_DELETE;
            end
            slht_pkg::ACT_DELIVER: begin
               out_fire = 1'b1;
               if (hit_any) begin
                  if (dead_ff[hit_idx]) begin
                     out_kind = slht_pkg::KIND_DROPPED;
                  end else begin
                     hbt_we   = 1'b1;
                     out_kind = slht_pkg::KIND_ROUTED;
                  end
               end else if (free_any) begin
                  valid_in[free_idx] = 1'b1;
                  dead_in[free_idx]  = 1'b1;
                  client_we          = 1'b1;
                  exp_we             = 1'b1;
                  exp_waddr          = free_idx;
                  exp_wdata          = '0;
                  hbt_we             = 1'b1;
                  hbt_waddr          = free_idx;
                  hbt_wdata          = '0;
                  out_kind           = slht_pkg::KIND_DROPPED;
               end else begin
                  out_kind = slht_pkg::KIND_FULL;
               end
            end
            slht_pkg::ACT_TICK: begin
               if (stat.tick_due) begin
                  next_check_in = new_check;
                  sw_idx_in     = '0;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.sw_eval) begin
         sw_idx_in  = sw_idx_ff + 1'b1;
         out_client = cur_client;
         out_last   = 1'b0;
         if (cur_valid) begin
            if (cur_dead || slht_pkg::reached(now_ff, exp_rd)) begin
               out_fire            = 1'b1;
               out_kind            = slht_pkg::KIND_EXPIRED;
               out_fwd             = slht_pkg::FWD_DELETE;
               valid_in[sw_idx_ff] = 1'b0;
               dead_in[sw_idx_ff]  = 1'b0;
            end else if (slht_pkg::reached(now_ff, hbt_rd)) begin
               out_fire  = 1'b1;
               out_kind  = slht_pkg::KIND_HEARTBEAT;
               hbt_we    = 1'b1;
               hbt_waddr = sw_idx_ff;
            end
         end
      end

      if (cmd.sw_done) begin
         out_fire   = 1'b1;
         out_kind   = slht_pkg::KIND_DONE;
         out_client = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         dead_ff       <= '0;
         next_check_ff <= '0;
         sw_idx_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         dead_ff       <= dead_in;
         next_check_ff <= next_check_in;
         sw_idx_ff     <= sw_idx_in;
         rsp_valid_ff  <= out_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (client_we) begin
         client_ff[free_idx] <= id_ff;
      end
   end

   assign out_ext = {{CW{1'b0}}, out_client};

   always_ff @(posedge clock) begin
      rsp_kind_ff   <= out_kind;
      rsp_client_ff <= out_ext[CW-1:0];
      rsp_fwd_ff    <= out_fwd;
      rsp_last_ff   <= out_last;
   end

   slht_ram #(
      .WIDTH (TW),
      .DEPTH (TABLE_DEPTH)
   ) u_exp_ram (
      .clock (clock),
      .we    (exp_we),
      .waddr (exp_waddr),
      .wdata (exp_wdata),
      .raddr (sw_idx_ff),
      .rdata (exp_rd)
   );

   slht_ram #(
      .WIDTH (TW),
      .DEPTH (TABLE_DEPTH)
   ) u_hbt_ram (
      .clock (clock),
      .we    (hbt_we),
      .waddr (hbt_waddr),
      .wdata (hbt_wdata),
      .raddr (sw_idx_ff),
      .rdata (hbt_rd)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_client_id_out   = rsp_client_ff;
   assign rsp_forward_command = rsp_fwd_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

// ===== rtl/subscription_lease_heartbeat_table.sv =====
// Subscription lease and heartbeat table, top level. Uses slht_pkg, slht_ctrl, slht_dp.
// Update, delete and deliver words: busy after accept, then one result on the ports
// in the next cycle; a new word is taken only once busy drops.
// Tick before check time: busy, no result. Tick that sweeps: busy through the sweep,
// each entry read over the deadline RAM read port, then evaluated. Results cannot be
// stalled. Sync reset clears valid/dead marks and check time, sets config to defaults.
module subscription_lease_heartbeat_table #(
   parameter int TABLE_DEPTH = slht_pkg::TABLE_DEPTH_DEF,
   parameter int ID_BITS     = slht_pkg::ID_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [slht_pkg::ACT_W-1:0]       req_action,
   input  logic [slht_pkg::CLIENT_W-1:0]    req_client_id,
   input  logic [slht_pkg::TIME_W-1:0]      req_now_ms,
   input  logic                             csr_we,
   input  logic [slht_pkg::CFG_IDX_W-1:0]   csr_index,
   input  logic [slht_pkg::CFG_W-1:0]       csr_wdata,
   output logic                             rsp_valid,
   output logic [slht_pkg::KIND_W-1:0]      rsp_kind,
   output logic [slht_pkg::CLIENT_W-1:0]    rsp_client_id_out,
   output logic [slht_pkg::FWD_W-1:0]       rsp_forward_command,
   output logic                             rsp_last
);

   slht_pkg::cmd_type  cmd;
   slht_pkg::stat_type stat;

   slht_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   slht_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_action          (req_action),
      .req_client_id       (req_client_id),
      .req_now_ms          (req_now_ms),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_kind            (rsp_kind),
      .rsp_client_id_out   (rsp_client_id_out),
      .rsp_forward_command (rsp_forward_command),
      .rsp_last            (rsp_last)
   );

endmodule

// ===== rtl/slht_checker.sv =====
// Port-level checks for the subscription lease and heartbeat table.
// Bound to the top level below. Depends on slht_pkg.
module slht_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic [slht_pkg::KIND_W-1:0]      rsp_kind,
   input logic [slht_pkg::CLIENT_W-1:0]    rsp_client_id_out,
   input logic                             rsp_last
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not make block busy");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without preceding work");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("final result while still busy");

   a_mid_sweep: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |->
         (rsp_kind == slht_pkg::KIND_EXPIRED || rsp_kind == slht_pkg::KIND_HEARTBEAT))
      else $error("non-final result is not a sweep notice");

   a_done_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == slht_pkg::KIND_DONE) |->
         (rsp_last && rsp_client_id_out == '0))
      else $error("sweep done result malformed");

endmodule

bind subscription_lease_heartbeat_table slht_checker u_slht_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_kind          (rsp_kind),
   .rsp_client_id_out (rsp_client_id_out),
   .rsp_last          (rsp_last)
);
